// File: src/vpp_pkg.sv
package vpp_pkg;

  localparam int MEM_BYTES_DEF = 16384;
  localparam int ADDR_W        = 14;
  localparam int NUM_BASES     = 5;

  localparam logic [2:0] KIND_CTRL   = 3'd0;
  localparam logic [2:0] KIND_DATA_W = 3'd1;
  localparam logic [2:0] KIND_DATA_R = 3'd2;
  localparam logic [2:0] KIND_STATUS = 3'd3;
  localparam logic [2:0] KIND_TICK   = 3'd4;

  localparam logic [1:0] CMD_ADDR_RD = 2'b00;
  localparam logic [1:0] CMD_ADDR_WR = 2'b01;
  localparam logic [1:0] CMD_REG     = 2'b10;
  localparam logic [1:0] CMD_NONE    = 2'b11;

  localparam logic [2:0] REG_MODE0 = 3'd0;
  localparam logic [2:0] REG_MODE1 = 3'd1;
  localparam logic [2:0] REG_NAME  = 3'd2;
  localparam logic [2:0] REG_COLOR = 3'd3;
  localparam logic [2:0] REG_PATT  = 3'd4;
  localparam logic [2:0] REG_COLORS = 3'd7;

  localparam logic [1:0] MODE_TEXT  = 2'd0;
  localparam logic [1:0] MODE_GFX1  = 2'd1;
  localparam logic [1:0] MODE_GFX2  = 2'd2;
  localparam logic [1:0] MODE_MULTI = 2'd3;

  localparam logic CFG_LPF = 1'b0;
  localparam logic CFG_VBL = 1'b1;

  localparam logic [8:0] LPF_RESET = 9'd262;
  localparam logic [8:0] VBL_RESET = 9'd192;

  localparam logic [7:0] BASE_MASKS [4][NUM_BASES] = '{
    '{8'h7F, 8'h00, 8'h3F, 8'h00, 8'h3F},
    '{8'h7F, 8'hFF, 8'h3F, 8'hFF, 8'h3F},
    '{8'h7F, 8'h80, 8'h3C, 8'hFF, 8'h3F},
    '{8'h7F, 8'h00, 8'h3F, 8'hFF, 8'h3F}
  };

  localparam int BASE_SHIFTS [NUM_BASES] = '{10, 6, 11, 7, 11};

  typedef struct packed {
    logic [1:0]                 mode;
    logic [NUM_BASES-1:0][13:0] bases;
    logic [7:0]                 colors;
    logic [13:0]                cmask;
    logic [13:0]                pmask;
    logic                       irq_en;
  } vpp_view_t;

  function automatic logic [13:0] calc_base(input logic [2:0] which, input logic [1:0] mode,
                                            input logic [7:0] v, input logic big);
    logic [7:0]  m;
    logic [21:0] w;
    m = v & BASE_MASKS[mode][which];
    w = {14'd0, m} << BASE_SHIFTS[which];
    return w[13:0] & (big ? 14'h3FFF : 14'h0FFF);
  endfunction

endpackage

// File: src/video_processor_host_port.sv
// Host port of a tile video processor. Each transaction on the input channel (control
// write, data write, data read, status read or scanline tick) yields exactly one result
// transaction carrying the read byte, the interrupt flag and the current table setup.
// After reset the video memory is cleared one byte per cycle, and the input is held off
// until the clear is done. Then one transaction is accepted every cycle while results
// are taken. A result passes through a stage register and then the output register, into
// which the byte from the registered read port of the video memory is merged.
module video_processor_host_port #(
  parameter int MEM_BYTES = vpp_pkg::MEM_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_kind,
  input  logic [7:0]  in_data_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_read_data,
  output logic        out_irq,
  output logic [1:0]  out_screen_mode,
  output logic [13:0] out_name_table_base,
  output logic [13:0] out_color_table_base,
  output logic [13:0] out_pattern_table_base,
  output logic [13:0] out_sprite_attr_base,
  output logic [13:0] out_sprite_pattern_base,
  output logic [3:0]  out_text_color,
  output logic [3:0]  out_backdrop_color,
  output logic [13:0] out_color_index_mask,
  output logic [13:0] out_pattern_index_mask,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data
);
  import vpp_pkg::*;

  localparam int AW = $clog2(MEM_BYTES);

  logic        expect_first_r, expect_first_nxt;
  logic [7:0]  latch_r, latch_nxt;
  logic        write_mode_r, write_mode_nxt;
  logic [13:0] addr_r, addr_nxt, addr_inc;
  logic        vblank_r, vblank_nxt;
  logic [8:0]  line_r, line_nxt, line_inc;
  logic [8:0]  lpf_r, vbl_r;

  logic          acc;
  logic          mem_en, mem_we, mem_busy;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_rdata;
  logic          reg_we, reg_irq, tick_irq, irq_nxt;
  logic [7:0]    status_rd;
  vpp_view_t     view_r, view_nxt;

  logic          s1_valid_r, s1_read_r, s1_irq_r, s1_move;
  logic [7:0]    s1_rd_r;
  vpp_view_t     s1_view_r;
  logic          out_valid_r, out_irq_r;
  logic [7:0]    out_rd_r;
  vpp_view_t     out_view_r;

  assign acc      = in_valid && in_ready;
  assign s1_move  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !mem_busy && (!s1_valid_r || s1_move);
  assign addr_inc = addr_r + 14'd1;
  assign line_inc = line_r + 9'd1;

  always_comb begin
    expect_first_nxt = expect_first_r;
    latch_nxt        = latch_r;
    write_mode_nxt   = write_mode_r;
    addr_nxt         = addr_r;
    vblank_nxt       = vblank_r;
    line_nxt         = line_r;
    mem_en           = 1'b0;
    mem_we           = 1'b0;
    mem_addr         = addr_r[AW-1:0];
    reg_we           = 1'b0;
    tick_irq         = 1'b0;
    status_rd        = 8'd0;
    if (acc) begin
      unique case (in_kind)
        KIND_CTRL: begin
          if (expect_first_r) begin
            expect_first_nxt = 1'b0;
            latch_nxt        = in_data_in;
          end else begin
            expect_first_nxt = 1'b1;
            unique case (in_data_in[7:6])
              CMD_ADDR_RD, CMD_ADDR_WR: begin
                addr_nxt       = {in_data_in[5:0], latch_r};
                write_mode_nxt = in_data_in[6];
              end
              CMD_REG:  reg_we = 1'b1;
              CMD_NONE: ;
            endcase
          end
        end
        KIND_DATA_W: begin
          mem_en   = 1'b1;
          mem_we   = 1'b1;
          mem_addr = write_mode_r ? addr_r[AW-1:0] : addr_inc[AW-1:0];
          addr_nxt = addr_inc;
        end
        KIND_DATA_R: begin
          mem_en   = 1'b1;
          addr_nxt = addr_inc;
        end
        KIND_STATUS: begin
          status_rd  = {vblank_r, 7'd0};
          vblank_nxt = 1'b0;
        end
        KIND_TICK: begin
          line_nxt = (line_inc >= lpf_r) ? 9'd0 : line_inc;
          if (line_nxt == vbl_r) begin
            tick_irq   = view_r.irq_en && !vblank_r;
            vblank_nxt = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  assign irq_nxt = tick_irq || reg_irq;

  vpp_vram #(
    .MEM_BYTES (MEM_BYTES)
  ) u_vram (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (in_data_in),
    .rdata (mem_rdata),
    .busy  (mem_busy)
  );

  vpp_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (reg_we),
    .wr_idx   (in_data_in[2:0]),
    .wr_val   (latch_r),
    .vblank   (vblank_r),
    .irq      (reg_irq),
    .view_r   (view_r),
    .view_nxt (view_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_first_r <= 1'b1;
      latch_r        <= 8'd0;
      write_mode_r   <= 1'b1;
      addr_r         <= 14'd0;
      vblank_r       <= 1'b0;
      line_r         <= 9'd0;
      lpf_r          <= LPF_RESET;
      vbl_r          <= VBL_RESET;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      expect_first_r <= expect_first_nxt;
      latch_r        <= latch_nxt;
      write_mode_r   <= write_mode_nxt;
      addr_r         <= addr_nxt;
      vblank_r       <= vblank_nxt;
      line_r         <= line_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LPF: lpf_r <= cfg_data;
          CFG_VBL: vbl_r <= cfg_data;
        endcase
      end
      if (acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // The memory byte of a data read is only available in the cycle after acceptance,
  // so it is merged in when the transaction moves into the output register.
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_read_r <= (in_kind == KIND_DATA_R);
      s1_rd_r   <= status_rd;
      s1_irq_r  <= irq_nxt;
      s1_view_r <= view_nxt;
    end
    if (s1_move) begin
      out_rd_r   <= s1_read_r ? mem_rdata : s1_rd_r;
      out_irq_r  <= s1_irq_r;
      out_view_r <= s1_view_r;
    end
  end

  assign out_valid               = out_valid_r;
  assign out_read_data           = out_rd_r;
  assign out_irq                 = out_irq_r;
  assign out_screen_mode         = out_view_r.mode;
  assign out_name_table_base     = out_view_r.bases[0];
  assign out_color_table_base    = out_view_r.bases[1];
  assign out_pattern_table_base  = out_view_r.bases[2];
  assign out_sprite_attr_base    = out_view_r.bases[3];
  assign out_sprite_pattern_base = out_view_r.bases[4];
  assign out_text_color          = out_view_r.colors[7:4];
  assign out_backdrop_color      = out_view_r.colors[3:0];
  assign out_color_index_mask    = out_view_r.cmask;
  assign out_pattern_index_mask  = out_view_r.pmask;

  a_rdata_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_read_r && !s1_move) |=> $stable(mem_rdata))
    else $error("memory read data changed while a read transaction was stalled");

  a_irq_vblank: assert property (@(posedge clk) disable iff (!rst_n)
    irq_nxt |=> vblank_r)
    else $error("interrupt raised without vblank being set");

  a_view_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !(acc && (in_kind == KIND_CTRL)) |=> $stable(view_r))
    else $error("register view changed without a control write");

  a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
    mem_busy |-> (!s1_valid_r && !out_valid_r))
    else $error("transaction in flight during memory clear");

endmodule

// File: src/vpp_vram.sv
module vpp_vram #(
  parameter int MEM_BYTES = vpp_pkg::MEM_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         we,
  input  logic [$clog2(MEM_BYTES)-1:0] addr,
  input  logic [7:0]                   wdata,
  output logic [7:0]                   rdata,
  output logic                         busy
);
  import vpp_pkg::*;

  localparam int AW = $clog2(MEM_BYTES);

  logic [7:0]    mem [MEM_BYTES];
  logic [AW-1:0] clr_addr_r;
  logic          busy_r;
  logic [7:0]    rdata_r;

  // The whole memory is zeroed one byte per cycle after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r     <= 1'b1;
      clr_addr_r <= '0;
    end else if (busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == {AW{1'b1}}) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_addr_r] <= 8'd0;
    end else if (en && we) begin
      mem[addr] <= wdata;
    end
    if (en && !we && !busy_r) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;
  assign busy  = busy_r;

endmodule

// File: src/vpp_regs.sv
module vpp_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [2:0]          wr_idx,
  input  logic [7:0]          wr_val,
  input  logic                vblank,
  output logic                irq,
  output vpp_pkg::vpp_view_t  view_r,
  output vpp_pkg::vpp_view_t  view_nxt
);
  import vpp_pkg::*;

  logic [7:0]                 regs_r [8];
  logic [7:0]                 regs_nxt [8];
  logic [1:0]                 mode_r, mode_nxt, mode_dec, mode_sel;
  logic [NUM_BASES-1:0][13:0] bases_r, bases_nxt;
  logic [13:0]                cmask_r, cmask_nxt, pmask_r, pmask_nxt;
  logic                       is_mode_reg, toggled, recompute, big;
  logic [2:0]                 sel;

  always_comb begin
    regs_nxt = regs_r;
    if (wr_en) begin
      regs_nxt[wr_idx] = wr_val;
    end
    is_mode_reg = wr_en && (wr_idx == REG_MODE0 || wr_idx == REG_MODE1);
    toggled     = wr_en && wr_idx == REG_MODE1 && (regs_r[1][7] ^ wr_val[7]);
    irq         = wr_en && wr_idx == REG_MODE1 && !regs_r[1][5] && wr_val[5] && vblank;
    big         = regs_nxt[1][7];
    sel         = {regs_nxt[1][3], regs_nxt[1][4], regs_nxt[0][1]};
    unique case (sel)
      3'd0:    mode_dec = MODE_GFX1;
      3'd1:    mode_dec = MODE_GFX2;
      3'd2:    mode_dec = MODE_TEXT;
      3'd4:    mode_dec = MODE_MULTI;
      default: mode_dec = mode_r;
    endcase
    mode_sel  = is_mode_reg ? mode_dec : mode_r;
    recompute = is_mode_reg && (mode_dec != mode_r || toggled);
    mode_nxt  = recompute ? mode_dec : mode_r;
    bases_nxt = bases_r;
    for (int i = 0; i < NUM_BASES; i++) begin
      if (recompute || (wr_en && wr_idx == REG_NAME + 3'(i))) begin
        bases_nxt[i] = calc_base(3'(i), mode_sel, regs_nxt[2 + i], big);
      end
    end
    cmask_nxt = cmask_r;
    if (recompute || (wr_en && wr_idx == REG_COLOR)) begin
      cmask_nxt = {regs_nxt[3] | 8'h80, 6'h3F};
    end
    pmask_nxt = pmask_r;
    if (recompute || (wr_en && wr_idx == REG_PATT)) begin
      pmask_nxt = {regs_nxt[4][2:0] | 3'b100, 11'h7FF};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        regs_r[i] <= 8'd0;
      end
      mode_r  <= MODE_TEXT;
      bases_r <= '0;
      cmask_r <= 14'h3FFF;
      pmask_r <= 14'h3FFF;
    end else begin
      regs_r  <= regs_nxt;
      mode_r  <= mode_nxt;
      bases_r <= bases_nxt;
      cmask_r <= cmask_nxt;
      pmask_r <= pmask_nxt;
    end
  end

  assign view_r   = '{mode: mode_r, bases: bases_r, colors: regs_r[REG_COLORS],
                      cmask: cmask_r, pmask: pmask_r, irq_en: regs_r[1][5]};
  assign view_nxt = '{mode: mode_nxt, bases: bases_nxt, colors: regs_nxt[REG_COLORS],
                      cmask: cmask_nxt, pmask: pmask_nxt, irq_en: regs_nxt[1][5]};

endmodule

// File: sim/host_port_checker.sv
`timescale 1ns / 1ps

module host_port_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  in_kind,
  input  logic [7:0]  in_data_in,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_read_data,
  input  logic        out_irq,
  input  logic [1:0]  out_screen_mode,
  input  logic [13:0] out_name_table_base,
  input  logic [13:0] out_color_table_base,
  input  logic [13:0] out_pattern_table_base,
  input  logic [13:0] out_sprite_attr_base,
  input  logic [13:0] out_sprite_pattern_base,
  input  logic [3:0]  out_text_color,
  input  logic [3:0]  out_backdrop_color,
  input  logic [13:0] out_color_index_mask,
  input  logic [13:0] out_pattern_index_mask,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data,
  output int          failures,
  output int          pending
);
  import vpp_pkg::*;

  localparam logic [2:0] REG_SATTR = 3'd5;
  localparam logic [2:0] REG_SPAT  = 3'd6;
  localparam int         SHOWN     = 10;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        irq;
    logic [1:0]  scr_mode;
    logic [13:0] name_base;
    logic [13:0] color_base;
    logic [13:0] pattern_base;
    logic [13:0] sattr_base;
    logic [13:0] spat_base;
    logic [3:0]  fg_color;
    logic [3:0]  bg_color;
    logic [13:0] cmask;
    logic [13:0] pmask;
  } port_view_t;

  logic [7:0]  vram [16384];
  logic [7:0]  vreg [8];
  logic [7:0]  status;
  logic [7:0]  latch;
  logic        first_byte;
  logic        wr_mode;
  logic [13:0] vaddr;
  logic [1:0]  scr_mode;
  logic [13:0] bases [5];
  logic [13:0] cmask;
  logic [13:0] pmask;
  logic [8:0]  line;
  logic [8:0]  lpf;
  logic [8:0]  vbl;
  port_view_t  views_due [$];
  int          fail_count;

  task automatic power_up();
    for (int i = 0; i < 16384; i++) vram[i] = 8'h00;
    for (int i = 0; i < 8; i++) vreg[i] = 8'h00;
    for (int i = 0; i < 5; i++) bases[i] = 14'h0000;
    status     = 8'h00;
    latch      = 8'h00;
    first_byte = 1'b1;
    wr_mode    = 1'b1;
    vaddr      = 14'h0000;
    scr_mode   = MODE_TEXT;
    cmask      = 14'h3FFF;
    pmask      = 14'h3FFF;
    line       = 9'd0;
    lpf        = LPF_RESET;
    vbl        = VBL_RESET;
    views_due.delete();
  endtask

  function automatic logic [13:0] table_addr(input int which, input logic [1:0] m,
                                             input logic [7:0] v, input logic big);
    logic [7:0]  keep;
    logic [21:0] wide;
    case (which)
      0: keep = 8'h7F;
      1: keep = (m == MODE_GFX1) ? 8'hFF : (m == MODE_GFX2) ? 8'h80 : 8'h00;
      2: keep = (m == MODE_GFX2) ? 8'h3C : 8'h3F;
      3: keep = (m == MODE_TEXT) ? 8'h00 : 8'hFF;
      default: keep = 8'h3F;
    endcase
    wide = {14'd0, v & keep};
    case (which)
      0: wide = wide << 10;
      1: wide = wide << 6;
      2: wide = wide << 11;
      3: wide = wide << 7;
      default: wide = wide << 11;
    endcase
    return wide[13:0] & (big ? 14'h3FFF : 14'h0FFF);
  endfunction

  task automatic refresh_masks();
    logic [7:0] hi;
    hi    = vreg[4] | 8'hFC;
    cmask = {vreg[3] | 8'h80, 6'h3F};
    pmask = {hi[2:0], 11'h7FF};
  endtask

  task automatic store_register(input logic [2:0] r, input logic [7:0] v, output logic irq);
    logic       flip;
    logic       big;
    logic [1:0] nm;
    irq  = 1'b0;
    flip = 1'b0;
    if (r == REG_MODE1) begin
      irq  = (((vreg[1] ^ v) & v & 8'h20) != 8'h00) && status[7];
      flip = vreg[1][7] ^ v[7];
    end
    vreg[r] = v;
    big = vreg[1][7];
    case (r)
      REG_MODE0, REG_MODE1: begin
        case ({vreg[1][3], vreg[1][4], vreg[0][1]})
          3'b000: nm = MODE_GFX1;
          3'b001: nm = MODE_GFX2;
          3'b010: nm = MODE_TEXT;
          3'b100: nm = MODE_MULTI;
          default: nm = scr_mode;
        endcase
        if (nm != scr_mode || flip) begin
          for (int i = 0; i < 5; i++) bases[i] = table_addr(i, nm, vreg[2 + i], big);
          refresh_masks();
          scr_mode = nm;
        end
      end
      REG_NAME: bases[0] = table_addr(0, scr_mode, vreg[2], big);
      REG_COLOR: begin
        bases[1] = table_addr(1, scr_mode, vreg[3], big);
        refresh_masks();
      end
      REG_PATT: begin
        bases[2] = table_addr(2, scr_mode, vreg[4], big);
        refresh_masks();
      end
      REG_SATTR: bases[3] = table_addr(3, scr_mode, vreg[5], big);
      REG_SPAT: bases[4] = table_addr(4, scr_mode, vreg[6], big);
      default: ;
    endcase
  endtask

  task automatic host_access(input logic [2:0] k, input logic [7:0] d,
                             output port_view_t v);
    logic [7:0] rd;
    logic       irq;
    rd  = 8'h00;
    irq = 1'b0;
    case (k)
      KIND_CTRL: begin
        if (first_byte) begin
          first_byte = 1'b0;
          latch      = d;
        end else begin
          first_byte = 1'b1;
          case (d[7:6])
            CMD_ADDR_RD, CMD_ADDR_WR: begin
              vaddr   = {d[5:0], latch};
              wr_mode = d[6];
            end
            CMD_REG: store_register(d[2:0], latch, irq);
            default: ;
          endcase
        end
      end
      KIND_DATA_W: begin
        if (wr_mode) begin
          vram[vaddr] = d;
          vaddr       = vaddr + 14'd1;
        end else begin
          vaddr       = vaddr + 14'd1;
          vram[vaddr] = d;
        end
      end
      KIND_DATA_R: begin
        rd    = vram[vaddr];
        vaddr = vaddr + 14'd1;
      end
      KIND_STATUS: begin
        rd     = status;
        status = status & 8'h1F;
      end
      KIND_TICK: begin
        line = line + 9'd1;
        if (line >= lpf) line = 9'd0;
        if (line == vbl) begin
          irq       = vreg[1][5] && !status[7];
          status[7] = 1'b1;
        end
      end
      default: ;
    endcase
    v.read_data    = rd;
    v.irq          = irq;
    v.scr_mode     = scr_mode;
    v.name_base    = bases[0];
    v.color_base   = bases[1];
    v.pattern_base = bases[2];
    v.sattr_base   = bases[3];
    v.spat_base    = bases[4];
    v.fg_color     = vreg[7][7:4];
    v.bg_color     = vreg[7][3:0];
    v.cmask        = cmask;
    v.pmask        = pmask;
  endtask

  task automatic compare_field(input string field, input int want, input int got);
    if (want != got) begin
      if (fail_count < SHOWN) begin
        $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, field, want, got);
      end
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    port_view_t got;
    port_view_t want;
    if (!rst_n) begin
      power_up();
    end else begin
      if (out_valid && out_ready) begin
        got = '{out_read_data, out_irq, out_screen_mode, out_name_table_base,
                out_color_table_base, out_pattern_table_base, out_sprite_attr_base,
                out_sprite_pattern_base, out_text_color, out_backdrop_color,
                out_color_index_mask, out_pattern_index_mask};
        if (views_due.size() == 0) begin
          if (fail_count < SHOWN) begin
            $display("%0t: result transaction with nothing outstanding, read_data %0d",
                     $realtime, out_read_data);
          end
          fail_count++;
        end else begin
          want = views_due.pop_front();
          compare_field("read_data", want.read_data, got.read_data);
          compare_field("irq", want.irq, got.irq);
          compare_field("screen_mode", want.scr_mode, got.scr_mode);
          compare_field("name_table_base", want.name_base, got.name_base);
          compare_field("color_table_base", want.color_base, got.color_base);
          compare_field("pattern_table_base", want.pattern_base, got.pattern_base);
          compare_field("sprite_attr_base", want.sattr_base, got.sattr_base);
          compare_field("sprite_pattern_base", want.spat_base, got.spat_base);
          compare_field("text_color", want.fg_color, got.fg_color);
          compare_field("backdrop_color", want.bg_color, got.bg_color);
          compare_field("color_index_mask", want.cmask, got.cmask);
          compare_field("pattern_index_mask", want.pmask, got.pmask);
        end
      end
      if (cfg_we) begin
        if (cfg_index == CFG_LPF) lpf = cfg_data;
        else vbl = cfg_data;
      end
      if (in_valid && in_ready) begin
        host_access(in_kind, in_data_in, want);
        views_due.push_back(want);
      end
    end
    failures <= fail_count;
    pending  <= views_due.size();
  end

endmodule

// File: sim/video_processor_host_port_test.sv
`timescale 1ns / 1ps

module video_processor_host_port_test;
  import vpp_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_kind;
  logic [7:0]  in_data_in;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_read_data;
  logic        out_irq;
  logic [1:0]  out_screen_mode;
  logic [13:0] out_name_table_base;
  logic [13:0] out_color_table_base;
  logic [13:0] out_pattern_table_base;
  logic [13:0] out_sprite_attr_base;
  logic [13:0] out_sprite_pattern_base;
  logic [3:0]  out_text_color;
  logic [3:0]  out_backdrop_color;
  logic [13:0] out_color_index_mask;
  logic [13:0] out_pattern_index_mask;
  logic        cfg_we;
  logic        cfg_index;
  logic [8:0]  cfg_data;
  int          failures;
  int          pending;
  int          items_sent;

  video_processor_host_port dut (.*);

  host_port_checker port_check (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("video_processor_host_port verification failed");
    $finish;
  end

  // The receiver holds off once for a long stretch so that the block backs up.
  initial begin
    int  taken;
    int  hold;
    bit  held;
    taken     = 0;
    hold      = 0;
    held      = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) taken++;
      if (!held && taken >= 300) begin
        held = 1'b1;
        hold = 80;
      end
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (taken >= 450 && taken < 600) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 22);
      end
    end
  end

  task automatic send_item(input logic [2:0] k, input logic [7:0] d);
    if (items_sent < 450 || items_sent >= 600) begin
      while ($urandom_range(99) < 22) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid   <= 1'b1;
    in_kind    <= k;
    in_data_in <= d;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic point_at(input logic [13:0] at, input logic writing);
    send_item(KIND_CTRL, at[7:0]);
    send_item(KIND_CTRL, {writing ? CMD_ADDR_WR : CMD_ADDR_RD, at[13:8]});
  endtask

  task automatic set_frame(input logic [8:0] lines, input logic [8:0] vb);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_LPF;
    cfg_data  <= lines;
    @(posedge clk);
    cfg_index <= CFG_VBL;
    cfg_data  <= vb;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic run_directed();
    logic [10:0] steps [27];
    steps = '{
      {KIND_STATUS, 8'h00},
      {KIND_CTRL, 8'h00}, {KIND_CTRL, {CMD_ADDR_WR, 6'h00}},
      {KIND_DATA_W, 8'hFF}, {KIND_DATA_W, 8'h00},
      {KIND_CTRL, 8'h00}, {KIND_CTRL, {CMD_ADDR_RD, 6'h00}},
      {KIND_DATA_R, 8'hFF}, {KIND_DATA_R, 8'h00},
      {KIND_DATA_W, 8'hA5},
      {KIND_CTRL, 8'hFF}, {KIND_CTRL, {CMD_ADDR_WR, 6'h3F}},
      {KIND_DATA_W, 8'h5A}, {KIND_DATA_R, 8'h00},
      {KIND_TICK, 8'h00},
      {KIND_CTRL, 8'hE0}, {KIND_CTRL, {CMD_REG, 3'b000, REG_MODE1}},
      {KIND_STATUS, 8'h00},
      {KIND_CTRL, 8'h02}, {KIND_CTRL, {CMD_REG, 3'b111, REG_MODE0}},
      {KIND_CTRL, 8'hFF}, {KIND_CTRL, {CMD_REG, 3'b000, REG_COLOR}},
      {KIND_CTRL, 8'hFF}, {KIND_CTRL, {CMD_REG, 3'b000, REG_PATT}},
      {KIND_CTRL, 8'h5A}, {KIND_CTRL, {CMD_NONE, 6'h2A}},
      {3'(KIND_TICK + 3'd3), 8'hFF}
    };
    foreach (steps[i]) send_item(steps[i][10:8], steps[i][7:0]);
  endtask

  task automatic run_random(input int goal, input int tick_pct);
    int          pick;
    int          n;
    logic [13:0] at;
    while (items_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < tick_pct) begin
        send_item(KIND_TICK, 8'($urandom));
      end else begin
        pick = $urandom_range(99);
        if (pick < 40) begin
          at = 14'($urandom);
          n  = $urandom_range(6, 1);
          point_at(at, 1'b1);
          repeat (n) send_item(KIND_DATA_W, 8'($urandom));
          point_at(at, 1'b0);
          repeat (n) send_item(KIND_DATA_R, 8'($urandom));
        end else if (pick < 70) begin
          send_item(KIND_CTRL, 8'($urandom));
          send_item(KIND_CTRL, {CMD_REG, 3'($urandom), 3'($urandom)});
        end else if (pick < 80) begin
          send_item(KIND_STATUS, 8'($urandom));
        end else if (pick < 87) begin
          point_at(14'($urandom), 1'b0);
          send_item(KIND_DATA_W, 8'($urandom));
          send_item(KIND_DATA_R, 8'($urandom));
        end else if (pick < 93) begin
          send_item(KIND_CTRL, 8'($urandom));
        end else if (pick < 97) begin
          send_item(KIND_CTRL, 8'($urandom));
          send_item(KIND_CTRL, {CMD_NONE, 6'($urandom)});
        end else begin
          send_item(3'(KIND_TICK + 3'($urandom_range(3, 1))), 8'($urandom));
        end
      end
    end
  endtask

  initial begin
    logic [8:0] lines;
    in_valid   = 1'b0;
    in_kind    = KIND_CTRL;
    in_data_in = 8'h00;
    cfg_we     = 1'b0;
    cfg_index  = CFG_LPF;
    cfg_data   = 9'd0;
    rst_n      = 1'b0;
    items_sent = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    set_frame(9'd200, 9'd1);
    run_directed();
    run_random(items_sent + 200, 30);
    settle();

    set_frame(9'd320, 9'd319);
    run_random(items_sent + 400, 95);
    settle();

    lines = 9'($urandom_range(320, 200));
    set_frame(lines, 9'($urandom_range(lines - 1, 1)));
    run_random(items_sent + 200, 45);
    settle();

    // With no frame length the line counter sits at zero.
    set_frame(9'd0, 9'd1);
    run_random(items_sent + 30, 30);
    settle();

    if (failures == 0) begin
      $display("video_processor_host_port verification clean");
    end else begin
      $display("video_processor_host_port verification failed");
    end
    $finish;
  end

endmodule

// File: video_processor_host_port.f
src/vpp_pkg.sv
src/vpp_vram.sv
src/vpp_regs.sv
src/video_processor_host_port.sv
sim/host_port_checker.sv
sim/video_processor_host_port_test.sv
